// File: design/fta_pkg.sv
// ============================================================================
// fta_pkg : shared types, constants and tables of the tilt angle block
// word types of both channels, register codes, fir and cordic tables
// ============================================================================
package fta_pkg;

    localparam int TAP_COUNT_DEF    = 30;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam int COEF_BITS    = 16;
    localparam int CFG_BITS     = 16;
    localparam int BIAS_SHIFT   = 12;
    localparam int GAIN_SHIFT   = 15;
    localparam int ANGLE_LIMIT  = 23040;
    localparam int Z_BITS       = 26;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [15:0] BIAS_X_RST = 16'd25726;
    localparam logic [15:0] BIAS_Y_RST = 16'd25502;
    localparam logic [15:0] BIAS_Z_RST = 16'd25561;
    localparam logic [15:0] GAIN_X_RST = 16'd37732;
    localparam logic [15:0] GAIN_Y_RST = 16'd38112;
    localparam logic [15:0] GAIN_Z_RST = 16'd38815;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BIAS_X = 3'd0,
        CFG_BIAS_Y = 3'd1,
        CFG_BIAS_Z = 3'd2,
        CFG_GAIN_X = 3'd3,
        CFG_GAIN_Y = 3'd4,
        CFG_GAIN_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] sample_x;
        logic [11:0] sample_y;
        logic [11:0] sample_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } t_out;

    // lane 0 is x, 1 is y, 2 is z
    typedef struct packed {
        logic [2:0][CFG_BITS-1:0] bias;
        logic [2:0][CFG_BITS-1:0] gain;
    } t_cfg;

    // symmetric low-pass taps, unsigned q0.16, zero past the end
    function automatic logic [COEF_BITS-1:0] fir_coef(input logic [5:0] idx);
        logic [COEF_BITS-1:0] c;
        case (idx)
            6'd1, 6'd28:  c = 16'd23;
            6'd2, 6'd27:  c = 16'd97;
            6'd3, 6'd26:  c = 16'd233;
            6'd4, 6'd25:  c = 16'd448;
            6'd5, 6'd24:  c = 16'd758;
            6'd6, 6'd23:  c = 16'd1171;
            6'd7, 6'd22:  c = 16'd1686;
            6'd8, 6'd21:  c = 16'd2287;
            6'd9, 6'd20:  c = 16'd2943;
            6'd10, 6'd19: c = 16'd3610;
            6'd11, 6'd18: c = 16'd4236;
            6'd12, 6'd17: c = 16'd4767;
            6'd13, 6'd16: c = 16'd5152;
            6'd14, 6'd15: c = 16'd5355;
            default:      c = 16'd0;
        endcase
        return c;
    endfunction

    // atan(2^-i) in degrees * 2^16
    function automatic logic signed [Z_BITS-1:0] atan_deg16(input logic [4:0] idx);
        logic signed [Z_BITS-1:0] a;
        case (idx)
            5'd0:  a = 26'sd2949120;
            5'd1:  a = 26'sd1740967;
            5'd2:  a = 26'sd919879;
            5'd3:  a = 26'sd466945;
            5'd4:  a = 26'sd234378;
            5'd5:  a = 26'sd117304;
            5'd6:  a = 26'sd58666;
            5'd7:  a = 26'sd29335;
            5'd8:  a = 26'sd14668;
            5'd9:  a = 26'sd7334;
            5'd10: a = 26'sd3667;
            5'd11: a = 26'sd1833;
            5'd12: a = 26'sd917;
            5'd13: a = 26'sd458;
            5'd14: a = 26'sd229;
            5'd15: a = 26'sd115;
            5'd16: a = 26'sd57;
            5'd17: a = 26'sd29;
            5'd18: a = 26'sd14;
            5'd19: a = 26'sd7;
            5'd20: a = 26'sd4;
            5'd21: a = 26'sd2;
            5'd22: a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: design/fta_front.sv
// ============================================================================
// fta_front : sample intake, fir filter and axis scaling
// shifts triples into the delay lines, runs the mac and pushes scaled axes
// ============================================================================
module fta_front #(
    parameter int TAP_COUNT   = fta_pkg::TAP_COUNT_DEF,
    parameter int SAMPLE_BITS = fta_pkg::SAMPLE_BITS_DEF,
    parameter int G_W         = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fta_pkg::t_in         i_in,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fta_pkg::t_cfg        i_cfg,
    output logic [3*G_W-1:0]     o_g,
    output logic                 o_g_valid,
    input  logic                 i_g_ready
);
    import fta_pkg::*;

    localparam int ACC_W   = SAMPLE_BITS + COEF_BITS + 1;
    localparam int BIAS_W  = CFG_BITS + BIAS_SHIFT;
    localparam int DIFF_W  = ((ACC_W > BIAS_W) ? ACC_W : BIAS_W) + 1;
    localparam int PROD_W  = DIFF_W + CFG_BITS + 1;
    localparam int IDX_W   = $clog2(TAP_COUNT);
    localparam int FILL_W  = $clog2(TAP_COUNT + 1);

    typedef enum logic [2:0] {F_IDLE, F_MAC, F_SUB, F_MUL, F_PUSH} t_fstate;

    t_fstate                  r_state;
    logic [FILL_W-1:0]        r_fill;
    logic [IDX_W-1:0]         r_idx;
    logic [SAMPLE_BITS-1:0]   r_dly [3][TAP_COUNT];
    logic [ACC_W-1:0]         r_acc [3];
    logic signed [DIFF_W-1:0] r_diff [3];
    logic signed [G_W-1:0]    r_g [3];

    logic [15:0]              w_ext [3];
    logic [ACC_W-1:0]         w_mac [3];
    logic signed [PROD_W-1:0] w_prod [3];
    logic [COEF_BITS-1:0]     w_coef;
    logic                     w_take;

    assign w_ext[0] = 16'(i_in.sample_x);
    assign w_ext[1] = 16'(i_in.sample_y);
    assign w_ext[2] = 16'(i_in.sample_z);
    assign w_coef   = fir_coef(6'(r_idx));
    assign w_take   = i_in_valid && o_in_ready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mac[k]  = ACC_W'(w_coef) * ACC_W'(r_dly[k][r_idx]);
            w_prod[k] = PROD_W'(r_diff[k]) * PROD_W'($signed({1'b0, i_cfg.gain[k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (w_take) begin
                        for (int k = 0; k < 3; k++) begin
                            for (int t = TAP_COUNT - 1; t > 0; t--) begin
                                r_dly[k][t] <= r_dly[k][t-1];
                            end
                            r_dly[k][0] <= w_ext[k][SAMPLE_BITS-1:0];
                            r_acc[k]    <= '0;
                        end
                        r_idx <= '0;
                        if (r_fill != FILL_W'(TAP_COUNT)) begin
                            r_fill <= r_fill + 1'b1;
                        end else begin
                            r_state <= F_MAC;
                        end
                    end
                end
                F_MAC: begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= r_acc[k] + w_mac[k];
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_W'(TAP_COUNT - 1)) begin
                        r_state <= F_SUB;
                    end
                end
                F_SUB: begin
                    for (int k = 0; k < 3; k++) begin
                        r_diff[k] <= $signed({{(DIFF_W-ACC_W){1'b0}}, r_acc[k]})
                                   - $signed({{(DIFF_W-BIAS_W){1'b0}}, i_cfg.bias[k],
                                              {BIAS_SHIFT{1'b0}}});
                    end
                    r_state <= F_MUL;
                end
                F_MUL: begin
                    // floor shift: keep the upper bits
                    for (int k = 0; k < 3; k++) begin
                        r_g[k] <= w_prod[k][PROD_W-1:GAIN_SHIFT];
                    end
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_g_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == F_IDLE);
    assign o_g_valid  = (r_state == F_PUSH);
    assign o_g        = {r_g[2], r_g[1], r_g[0]};

endmodule

// File: design/fta_queue.sv
// ============================================================================
// fta_queue : two-entry queue between front and back
// holds scaled axis triples so either side can stall on its own
// ============================================================================
module fta_queue #(
    parameter int W = 96
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_data,
    input  logic         i_valid,
    output logic         o_ready,
    output logic [W-1:0] o_data,
    output logic         o_valid,
    input  logic         i_ready
);
    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue push lost");
    a_cnt_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("queue pop lost");

endmodule

// File: design/fta_back.sv
// ============================================================================
// fta_back : radius and angle unit
// three lanes: squares, bit-pair square root, vectoring cordic, rounding
// ============================================================================
module fta_back #(
    parameter int G_W          = 32,
    parameter int CORDIC_STEPS = fta_pkg::CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [3*G_W-1:0] i_g,
    input  logic             i_g_valid,
    output logic             o_g_ready,
    output fta_pkg::t_out    o_out,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    import fta_pkg::*;

    localparam int N_W     = 2 * G_W + 2;
    localparam int R_W     = G_W + 1;
    localparam int REM_W   = G_W + 3;
    localparam int X_W     = G_W + 3;
    localparam int SQ_N    = G_W + 1;
    localparam int CS_N    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CNT_MAX = (SQ_N > CS_N) ? SQ_N : CS_N;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int ZS_W    = Z_BITS - 8;

    typedef enum logic [2:0] {B_IDLE, B_SQ, B_SUM, B_SQRT, B_CORD, B_FIN, B_OUT} t_bstate;

    t_bstate                  r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [G_W-1:0]    r_g [3];
    logic [2*G_W-1:0]         r_sq [3];
    logic [N_W-1:0]           r_n [3];
    logic [REM_W-1:0]         r_rem [3];
    logic [R_W-1:0]           r_root [3];
    logic signed [X_W-1:0]    r_x [3];
    logic signed [X_W-1:0]    r_y [3];
    logic signed [Z_BITS-1:0] r_z [3];
    logic signed [15:0]       r_ang [3];
    t_out                     r_out;
    logic                     r_out_valid;

    logic [G_W-1:0]           w_abs [3];
    logic [REM_W-1:0]         w_rem [3];
    logic [REM_W-1:0]         w_trial [3];
    logic                     w_ge [3];
    logic signed [X_W-1:0]    w_dx [3];
    logic signed [X_W-1:0]    w_dy [3];
    logic signed [Z_BITS-1:0] w_zr [3];
    logic signed [ZS_W-1:0]   w_res [3];
    logic signed [Z_BITS-1:0] w_atan;

    assign w_atan = atan_deg16(5'(r_cnt));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k]   = r_g[k][G_W-1] ? G_W'(-r_g[k]) : G_W'(r_g[k]);
            w_rem[k]   = {r_rem[k][REM_W-3:0], r_n[k][N_W-1:N_W-2]};
            w_trial[k] = {r_root[k], 2'b01};
            w_ge[k]    = (w_rem[k] >= w_trial[k]);
            w_dx[k]    = r_y[k] >>> r_cnt;
            w_dy[k]    = r_x[k] >>> r_cnt;
            w_zr[k]    = r_z[k] + Z_BITS'(128);
            w_res[k]   = w_zr[k][Z_BITS-1:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == B_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_g_valid) begin
                        for (int k = 0; k < 3; k++) begin
                            r_g[k] <= i_g[k*G_W +: G_W];
                        end
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sq[k] <= (2*G_W)'(w_abs[k]) * (2*G_W)'(w_abs[k]);
                    end
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    // lane k takes the squares of the other two axes
                    r_n[0] <= N_W'(r_sq[1]) + N_W'(r_sq[2]);
                    r_n[1] <= N_W'(r_sq[0]) + N_W'(r_sq[2]);
                    r_n[2] <= N_W'(r_sq[0]) + N_W'(r_sq[1]);
                    for (int k = 0; k < 3; k++) begin
                        r_rem[k]  <= '0;
                        r_root[k] <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_rem[k]  <= w_ge[k] ? (w_rem[k] - w_trial[k]) : w_rem[k];
                        r_root[k] <= {r_root[k][R_W-2:0], w_ge[k]};
                        r_n[k]    <= {r_n[k][N_W-3:0], 2'b00};
                    end
                    if (r_cnt == CNT_W'(SQ_N - 1)) begin
                        r_cnt   <= '0;
                        r_state <= B_CORD;
                        for (int k = 0; k < 3; k++) begin
                            r_x[k] <= $signed({1'b0, {r_root[k][R_W-2:0], w_ge[k]},
                                               1'b0}) >>> 1;
                            r_y[k] <= X_W'(r_g[k]);
                            r_z[k] <= '0;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_CORD: begin
                    for (int k = 0; k < 3; k++) begin
                        if (!r_y[k][X_W-1]) begin
                            r_x[k] <= r_x[k] + w_dx[k];
                            r_y[k] <= r_y[k] - w_dy[k];
                            r_z[k] <= r_z[k] + w_atan;
                        end else begin
                            r_x[k] <= r_x[k] - w_dx[k];
                            r_y[k] <= r_y[k] + w_dy[k];
                            r_z[k] <= r_z[k] - w_atan;
                        end
                    end
                    if (r_cnt == CNT_W'(CS_N - 1)) begin
                        r_cnt   <= '0;
                        r_state <= B_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_FIN: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_root[k] == '0) begin
                            // other two axes zero: full scale by own sign
                            if (r_g[k] > 0) begin
                                r_ang[k] <= 16'(ANGLE_LIMIT);
                            end else if (r_g[k] < 0) begin
                                r_ang[k] <= -16'(ANGLE_LIMIT);
                            end else begin
                                r_ang[k] <= '0;
                            end
                        end else if (w_res[k] > ZS_W'(ANGLE_LIMIT)) begin
                            r_ang[k] <= 16'(ANGLE_LIMIT);
                        end else if (w_res[k] < -ZS_W'(ANGLE_LIMIT)) begin
                            r_ang[k] <= -16'(ANGLE_LIMIT);
                        end else begin
                            r_ang[k] <= 16'(w_res[k]);
                        end
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.angle_x <= r_ang[0];
                        r_out.angle_y <= r_ang[1];
                        r_out.angle_z <= r_ang[2];
                        r_state       <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_g_ready   = (r_state == B_IDLE);
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// File: design/fir_filtered_tilt_angles.sv
// ============================================================================
// fir_filtered_tilt_angles : accelerometer tilt angles after fir low-pass
// filters each axis, removes bias, scales to g and returns three tilt angles
// ============================================================================
//
//  channel   handshake                      word
//  -------   ----------------------------   ------------------------------
//  input     i_in_valid / o_in_ready        i_in  : sample_x/_y/_z, 12 bit
//  output    o_out_valid / i_out_ready      o_out : angle_x/_y/_z, q8 deg
//  config    i_cfg_we                       i_cfg_index, i_cfg_data
//
//  front: intake, mac over TAP_COUNT taps, bias subtract, gain multiply, push;
//    a single shared mac per axis walks the delay lines
//  back: intake, squares, sums, bit-pair root loop, cordic loop, clamp, output;
//    the root and cordic loops take most of the time
//  front and back work on different words at once, each taking a new word when idle
//  the first TAP_COUNT words only fill the delay lines
//  synchronous active-low reset; no clearing pass, delay lines are read only
//  after being filled; a two-entry queue and an output register absorb stalls
//
module fir_filtered_tilt_angles #(
    parameter int TAP_COUNT    = fta_pkg::TAP_COUNT_DEF,
    parameter int SAMPLE_BITS  = fta_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = fta_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fta_pkg::t_in                      i_in,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    output fta_pkg::t_out                     o_out,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_cfg_we,
    input  logic [fta_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fta_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import fta_pkg::*;

    // scaled axis width, same chain as the front computes
    localparam int ACC_W  = SAMPLE_BITS + COEF_BITS + 1;
    localparam int BIAS_W = CFG_BITS + BIAS_SHIFT;
    localparam int DIFF_W = ((ACC_W > BIAS_W) ? ACC_W : BIAS_W) + 1;
    localparam int G_W    = DIFF_W + CFG_BITS + 1 - GAIN_SHIFT;

    t_cfg             r_cfg;
    logic [3*G_W-1:0] w_fg;
    logic             w_fg_valid;
    logic             w_fg_ready;
    logic [3*G_W-1:0] w_bg;
    logic             w_bg_valid;
    logic             w_bg_ready;

    // register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bias[0] <= BIAS_X_RST;
            r_cfg.bias[1] <= BIAS_Y_RST;
            r_cfg.bias[2] <= BIAS_Z_RST;
            r_cfg.gain[0] <= GAIN_X_RST;
            r_cfg.gain[1] <= GAIN_Y_RST;
            r_cfg.gain[2] <= GAIN_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIAS_X: r_cfg.bias[0] <= i_cfg_data;
                CFG_BIAS_Y: r_cfg.bias[1] <= i_cfg_data;
                CFG_BIAS_Z: r_cfg.bias[2] <= i_cfg_data;
                CFG_GAIN_X: r_cfg.gain[0] <= i_cfg_data;
                CFG_GAIN_Y: r_cfg.gain[1] <= i_cfg_data;
                CFG_GAIN_Z: r_cfg.gain[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: intake, fir mac and scaling
    fta_front #(
        .TAP_COUNT  (TAP_COUNT),
        .SAMPLE_BITS(SAMPLE_BITS),
        .G_W        (G_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_cfg     (r_cfg),
        .o_g       (w_fg),
        .o_g_valid (w_fg_valid),
        .i_g_ready (w_fg_ready)
    );

    // decoupling queue of scaled axis words
    fta_queue #(
        .W(3 * G_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_data (w_fg),
        .i_valid(w_fg_valid),
        .o_ready(w_fg_ready),
        .o_data (w_bg),
        .o_valid(w_bg_valid),
        .i_ready(w_bg_ready)
    );

    // back: radius, cordic and output register
    fta_back #(
        .G_W         (G_W),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_g        (w_bg),
        .i_g_valid  (w_bg_valid),
        .o_g_ready  (w_bg_ready),
        .o_out      (o_out),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready)
    );

    // every delivered angle stays inside plus or minus ninety degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.angle_x <= 16'sd23040 && o_out.angle_x >= -16'sd23040
                      && o_out.angle_y <= 16'sd23040 && o_out.angle_y >= -16'sd23040
                      && o_out.angle_z <= 16'sd23040 && o_out.angle_z >= -16'sd23040))
        else $error("angle out of range");

endmodule

// File: test/fir_filtered_tilt_angles_test.sv
// ============================================================================
// fir_filtered_tilt_angles_test : self-checking bench for the tilt angle block
// drives sample words through the fir, bias, gain and cordic path under random
// stalls on both channels, predicts every angle word in a scoreboard and
// walks the bias and gain registers through defaults, zero gains and extremes
// ============================================================================
`timescale 1ns / 1ps

module fir_filtered_tilt_angles_test;
    import fta_pkg::*;

    localparam int  LINE_DEPTH   = 30;
    localparam int  ROTATIONS    = 16;
    localparam int  SETTLE_TICKS = 150;
    localparam int  TICK_LIMIT   = 1000000;

    // register indexes that the block must ignore
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of delay lines and registers, queue of angle words
    // ------------------------------------------------------------------------
    class tilt_scoreboard;
        int unsigned fir_tap [LINE_DEPTH] = '{
            0, 23, 97, 233, 448, 758, 1171, 1686, 2287, 2943,
            3610, 4236, 4767, 5152, 5355, 5355, 5152, 4767, 4236, 3610,
            2943, 2287, 1686, 1171, 758, 448, 233, 97, 23, 0};
        longint atan_step [ROTATIONS] = '{
            2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115};
        logic [11:0] lines [3][LINE_DEPTH];
        int          fill_count;
        logic [15:0] bias [3];
        logic [15:0] gain [3];
        t_out        angle_q [$];
        int          errors;

        function new();
            foreach (lines[a, t]) lines[a][t] = '0;
            fill_count = 0;
            errors     = 0;
            bias = '{BIAS_X_RST, BIAS_Y_RST, BIAS_Z_RST};
            gain = '{GAIN_X_RST, GAIN_Y_RST, GAIN_Z_RST};
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] v);
            case (idx)
                CFG_BIAS_X: bias[0] = v;
                CFG_BIAS_Y: bias[1] = v;
                CFG_BIAS_Z: bias[2] = v;
                CFG_GAIN_X: gain[0] = v;
                CFG_GAIN_Y: gain[1] = v;
                CFG_GAIN_Z: gain[2] = v;
                default: ;
            endcase
        endfunction

        // filtered, de-biased axis in 2^-25 g
        function longint axis_g(int a);
            longint acc;
            acc = 0;
            for (int t = 0; t < LINE_DEPTH; t++)
                acc += longint'(fir_tap[t]) * longint'(lines[a][t]);
            acc = acc - (longint'(bias[a]) <<< BIAS_SHIFT);
            return (acc * longint'(gain[a])) >>> GAIN_SHIFT;
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic signed [15:0] tilt(longint a, longint b, longint c);
            longint unsigned ub, uc;
            longint x, y, z, dx, dy, res;
            ub = (b < 0) ? -b : b;
            uc = (c < 0) ? -c : c;
            x  = longint'(root_floor(ub * ub + uc * uc));
            if (x == 0)
                return 16'((a > 0) ? ANGLE_LIMIT : ((a < 0) ? -ANGLE_LIMIT : 0));
            y = a;
            z = 0;
            for (int i = 0; i < ROTATIONS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_step[i];
                end else begin
                    x -= dx; y += dy; z -= atan_step[i];
                end
            end
            res = (z + 128) >>> 8;
            if (res > ANGLE_LIMIT) res = ANGLE_LIMIT;
            if (res < -ANGLE_LIMIT) res = -ANGLE_LIMIT;
            return res[15:0];
        endfunction

        function void note_word(t_in w);
            longint gx, gy, gz;
            t_out   e;
            for (int t = LINE_DEPTH - 1; t > 0; t--)
                for (int a = 0; a < 3; a++) lines[a][t] = lines[a][t-1];
            lines[0][0] = w.sample_x;
            lines[1][0] = w.sample_y;
            lines[2][0] = w.sample_z;
            if (fill_count < LINE_DEPTH) begin
                fill_count++;
                return;
            end
            gx = axis_g(0);
            gy = axis_g(1);
            gz = axis_g(2);
            e.angle_x = tilt(gx, gy, gz);
            e.angle_y = tilt(gy, gx, gz);
            e.angle_z = tilt(gz, gx, gy);
            angle_q.push_back(e);
        endfunction

        function void check_word(t_out got);
            t_out e;
            if (angle_q.size() == 0) begin
                $error("unexpected angle word %h", got);
                errors++;
                return;
            end
            e = angle_q.pop_front();
            if (got.angle_x !== e.angle_x) begin
                $error("angle_x expected %0d actual %0d", e.angle_x, got.angle_x);
                errors++;
            end
            if (got.angle_y !== e.angle_y) begin
                $error("angle_y expected %0d actual %0d", e.angle_y, got.angle_y);
                errors++;
            end
            if (got.angle_z !== e.angle_z) begin
                $error("angle_z expected %0d actual %0d", e.angle_z, got.angle_z);
                errors++;
            end
        endfunction

        function int pending();
            return angle_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block and its drivers
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    t_in                     in_word;
    logic                    in_valid;
    logic                    in_ready;
    t_out                    out_word;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    tilt_scoreboard sb;
    bit             quiet;          // no idling on either side
    int             stall_left = 0;
    int             ticks = 0;
    int             drift [3];      // slow center per axis for realistic words

    fir_filtered_tilt_angles i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_word),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .o_out       (out_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle guard against a hung handshake
    always @(posedge i_clk) begin
        ticks <= ticks + 1;
        if (ticks > TICK_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, none when quiet
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result monitor, pre-edge values are the ones the edge accepts
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_word(out_word);
    end

    // one input word, optional gap before it; valid held until accepted
    task automatic send_word(input t_in w);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        t_in w;
        w.sample_x = x[11:0];
        w.sample_y = y[11:0];
        w.sample_z = z[11:0];
        send_word(w);
    endtask

    // drop valid, wait for every angle word, then let the back end settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // all six registers, plus one write to an unused index that must do nothing
    task automatic load_regs(input logic [15:0] b [3], input logic [15:0] g [3]);
        t_cfg_idx                idx [6];
        logic [15:0]             val [6];
        idx = '{CFG_BIAS_X, CFG_BIAS_Y, CFG_BIAS_Z, CFG_GAIN_X, CFG_GAIN_Y, CFG_GAIN_Z};
        val = '{b[0], b[1], b[2], g[0], g[1], g[2]};
        for (int k = 0; k < 6; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
        end
        cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
        cfg_data  <= 16'($urandom);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // sample code: mostly a slow drift near mid scale, some noise and extremes
    function automatic int pick_code(int a);
        int m;
        m = $urandom_range(0, 9);
        if (m < 6) begin
            drift[a] = drift[a] + $urandom_range(0, 80) - 40;
            if (drift[a] < 0) drift[a] = 0;
            if (drift[a] > 4095) drift[a] = 4095;
            return drift[a];
        end
        if (m < 9) return $urandom_range(0, 4095);
        return ($urandom_range(0, 1) != 0) ? 4095 : 0;
    endfunction

    task automatic random_words(input int n);
        for (int k = 0; k < n; k++) send_xyz(pick_code(0), pick_code(1), pick_code(2));
    endtask

    initial begin
        logic [15:0] b [3];
        logic [15:0] g [3];
        sb         = new();
        quiet      = 1'b0;
        drift      = '{1600, 1580, 1900};
        i_rst_n    = 1'b0;
        in_word    = '0;
        in_valid   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_BIAS_X;
        cfg_data   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the delay lines at reset settings, then extreme words
        for (int k = 0; k < LINE_DEPTH; k++) send_xyz(k * 141, 4095 - k * 137, k * 99);
        send_xyz(0, 0, 0);
        send_xyz(4095, 4095, 4095);
        send_xyz(4095, 0, 0);
        send_xyz(0, 4095, 0);
        send_xyz(0, 0, 4095);
        send_xyz(12'hAAA, 12'h555, 12'hAAA);
        drain();

        // all gains zero: every angle is zero
        b = '{BIAS_X_RST, BIAS_Y_RST, BIAS_Z_RST};
        g = '{16'd0, 16'd0, 16'd0};
        load_regs(b, g);
        send_xyz(4095, 0, 2000);
        send_xyz(100, 3000, 4095);
        drain();

        // two gains zero: the remaining axis pins at plus or minus 90 degrees
        for (int a = 0; a < 3; a++) begin
            g = '{16'd0, 16'd0, 16'd0};
            g[a] = 16'hFFFF;
            load_regs(b, g);
            for (int k = 0; k < 4; k++) send_xyz(4095, 4095, 4095);
            for (int k = 0; k < 4; k++) send_xyz(0, 0, 0);
            drain();
        end

        // register extremes
        b = '{16'd0, 16'd0, 16'd0};
        g = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_regs(b, g);
        random_words(40);
        drain();
        b = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_regs(b, g);
        random_words(40);
        drain();
        b = '{16'd0, 16'hFFFF, 16'd25600};
        g = '{16'd1, 16'd40000, 16'hFFFF};
        load_regs(b, g);
        random_words(40);
        drain();

        // random settings, mostly near real sensor values
        for (int p = 0; p < 5; p++) begin
            for (int a = 0; a < 3; a++) begin
                b[a] = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(24000, 28000))
                                                   : 16'($urandom);
                g[a] = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(30000, 45000))
                                                   : 16'($urandom);
            end
            load_regs(b, g);
            random_words(260);
            drain();
        end

        // back to reset values, last part without idling
        b = '{BIAS_X_RST, BIAS_Y_RST, BIAS_Z_RST};
        g = '{GAIN_X_RST, GAIN_Y_RST, GAIN_Z_RST};
        load_regs(b, g);
        quiet = 1'b1;
        random_words(200);
        drain();

        if (sb.pending() != 0) begin
            $error("%0d angle words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
